// ===== hdl/bounding_sphere_merge_macros.svh =====
// Assertion helpers for the bounding sphere merge block.
`ifndef BOUNDING_SPHERE_MERGE_MACROS_SVH
`define BOUNDING_SPHERE_MERGE_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define BSM_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check an implication into the following cycle.
`define BSM_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hdl/bsm_pkg.sv =====
`timescale 1ns / 1ps
package bsm_pkg;

	localparam int CoordW = 32;
	localparam int RadW = 31;
	localparam int SqrtBits = 35;
	localparam int QuoBits = 64;
	localparam int DivStages = 16;
	localparam int DivBitsPerStage = QuoBits / DivStages;
	localparam int D2W = 67;
	localparam int NumW = 96;
	localparam logic [RadW-1:0] RadMax = {RadW{1'b1}};

	// Payload that walks the row of square root cells.
	typedef struct packed {
		logic signed [CoordW-1:0] c1x, c1y, c1z;
		logic signed [CoordW:0] dx, dy, dz;
		logic [RadW-1:0] r1, r2;
		logic [D2W-1:0] d2;
		logic encl;
		logic encl_first;
		logic ovl;
	} sq_data_t;

	// Payload that walks the row of divider cells.
	typedef struct packed {
		logic signed [CoordW-1:0] c1x, c1y, c1z;
		logic sx, sy, sz;
		logic [SqrtBits:0] rw;
		logic [RadW-1:0] r1;
		logic [SqrtBits-1:0] d;
		logic [NumW-1:0] nx, ny, nz;
		logic [QuoBits-1:0] qx, qy, qz;
		logic [SqrtBits:0] remx, remy, remz;
		logic encl;
		logic ovl;
	} dv_data_t;

	// One restoring division bit step; remainder stays below 2*d.
	function automatic logic [SqrtBits+QuoBits:0] div_bit(
		input logic [SqrtBits:0] rem, input logic nb, input logic [SqrtBits-1:0] d);
		logic [SqrtBits+1:0] t;
		logic [SqrtBits+1:0] s;
		begin
			t = {rem, nb};
			s = t - {2'b00, d};
			if (!s[SqrtBits+1]) return {s[SqrtBits:0], {QuoBits{1'b0}}} | 1'b1;
			else return {t[SqrtBits:0], {QuoBits{1'b0}}};
		end
	endfunction

endpackage

// ===== hdl/bsm_sqrt_cell.sv =====
`timescale 1ns / 1ps
module bsm_sqrt_cell import bsm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic [5:0] bit_idx,
	input  logic vin,
	input  sq_data_t din,
	input  logic [SqrtBits-1:0] rin,
	output logic vout,
	output sq_data_t dout,
	output logic [SqrtBits-1:0] rout
);
	logic [SqrtBits-1:0] cand;
	logic [2*SqrtBits-1:0] sq;

	// Try one result bit against the squared distance.
	always_comb begin
		cand = rin | (SqrtBits'(1) << bit_idx);
		sq = cand * cand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (adv) begin
			vout <= vin;
		end
	end

	// Hand the partial root to the next cell.
	always_ff @(posedge clk) begin
		if (adv) begin
			dout <= din;
			rout <= (sq <= (2*SqrtBits)'(din.d2)) ? cand : rin;
		end
	end
endmodule

// ===== hdl/bsm_div_cell.sv =====
`timescale 1ns / 1ps
module bsm_div_cell import bsm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic vin,
	input  dv_data_t din,
	output logic vout,
	output dv_data_t dout
);
	dv_data_t nx;

	// Advance every axis by DivBitsPerStage (4) quotient bits.
	always_comb begin
		logic [SqrtBits+QuoBits:0] r;
		nx = din;
		for (int i = 0; i < DivBitsPerStage; i++) begin
			r = div_bit(nx.remx, nx.nx[NumW-1], nx.d);
			nx.remx = r[SqrtBits+QuoBits:QuoBits];
			nx.qx = {nx.qx[QuoBits-2:0], r[0]};
			nx.nx = {nx.nx[NumW-2:0], 1'b0};
			r = div_bit(nx.remy, nx.ny[NumW-1], nx.d);
			nx.remy = r[SqrtBits+QuoBits:QuoBits];
			nx.qy = {nx.qy[QuoBits-2:0], r[0]};
			nx.ny = {nx.ny[NumW-2:0], 1'b0};
			r = div_bit(nx.remz, nx.nz[NumW-1], nx.d);
			nx.remz = r[SqrtBits+QuoBits:QuoBits];
			nx.qz = {nx.qz[QuoBits-2:0], r[0]};
			nx.nz = {nx.nz[NumW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (adv) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) dout <= nx;
	end
endmodule

// ===== hdl/bounding_sphere_merge.sv =====
// Pipeline: 3 front stages, 35 root cells, 2 setup stages, 16 divider cells and 4 output stages,
// a chain of root and divider cells from input beat to output beat.
// Throughput: one sphere pair per cycle; the whole chain stalls when m_axis_tready is low
// while an output beat is held.
// Reset: arst_n clears all valid flags asynchronously; payload registers are not reset.
`timescale 1ns / 1ps
`include "bounding_sphere_merge_macros.svh"
module bounding_sphere_merge import bsm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// first_center_x, first_center_y, first_center_z, first_radius,
	// second_center_x, second_center_y, second_center_z, second_radius
	input  logic [255:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// merged_center_x, merged_center_y, merged_center_z, merged_radius,
	// radius_growth, spheres_overlap, saturated
	output logic [191:0] m_axis_tdata
);
	logic adv;
	logic v_s1, v_s2, v_s3;
	logic signed [CoordW-1:0] c1x_s1, c1y_s1, c1z_s1;
	logic signed [CoordW:0] dx_s1, dy_s1, dz_s1;
	logic [RadW-1:0] r1_s1, r2_s1;
	logic [65:0] px_s2, py_s2, pz_s2;
	logic [63:0] sum2_s2, rd2_s2;
	sq_data_t sq_s2, sq_s3;
	logic [RadW:0] sum_s1, rdif_s1;

	// Stall the whole chain only while a beat waits at the output.
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// Unpack and take differences.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c1x_s1 <= s_axis_tdata[31:0];
			c1y_s1 <= s_axis_tdata[63:32];
			c1z_s1 <= s_axis_tdata[95:64];
			r1_s1 <= s_axis_tdata[126:96];
			dx_s1 <= $signed({s_axis_tdata[158], s_axis_tdata[158:127]})
				- $signed({s_axis_tdata[31], s_axis_tdata[31:0]});
			dy_s1 <= $signed({s_axis_tdata[190], s_axis_tdata[190:159]})
				- $signed({s_axis_tdata[63], s_axis_tdata[63:32]});
			dz_s1 <= $signed({s_axis_tdata[222], s_axis_tdata[222:191]})
				- $signed({s_axis_tdata[95], s_axis_tdata[95:64]});
			r2_s1 <= s_axis_tdata[253:223];
		end
	end

	assign sum_s1 = {1'b0, r1_s1} + {1'b0, r2_s1};
	assign rdif_s1 = (r2_s1 > r1_s1) ? {1'b0, r2_s1 - r1_s1} : {1'b0, r1_s1 - r2_s1};

	// Square the differences and radius terms.
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2 <= $unsigned(66'(dx_s1) * 66'(dx_s1));
			py_s2 <= $unsigned(66'(dy_s1) * 66'(dy_s1));
			pz_s2 <= $unsigned(66'(dz_s1) * 66'(dz_s1));
			sum2_s2 <= sum_s1 * sum_s1;
			rd2_s2 <= rdif_s1 * rdif_s1;
			sq_s2.c1x <= c1x_s1;
			sq_s2.c1y <= c1y_s1;
			sq_s2.c1z <= c1z_s1;
			sq_s2.dx <= dx_s1;
			sq_s2.dy <= dy_s1;
			sq_s2.dz <= dz_s1;
			sq_s2.r1 <= r1_s1;
			sq_s2.r2 <= r2_s1;
			sq_s2.d2 <= '0;
			sq_s2.encl <= 1'b0;
			sq_s2.encl_first <= r1_s1 > r2_s1;
			sq_s2.ovl <= 1'b0;
		end
	end

	// Sum the squares and run the tests.
	always_ff @(posedge clk) begin
		logic [D2W-1:0] d2;
		sq_data_t nxt;
		if (adv) begin
			d2 = D2W'(px_s2) + D2W'(py_s2) + D2W'(pz_s2);
			nxt = sq_s2;
			nxt.d2 = d2;
			nxt.ovl = D2W'(sum2_s2) > d2;
			nxt.encl = d2 <= D2W'(rd2_s2);
			sq_s3 <= nxt;
		end
	end

	// Row of square root cells, one result bit per cell.
	logic sv [SqrtBits+1];
	sq_data_t sd [SqrtBits+1];
	logic [SqrtBits-1:0] sr [SqrtBits+1];
	assign sv[0] = v_s3;
	assign sd[0] = sq_s3;
	assign sr[0] = '0;
	for (genvar g = 0; g < SqrtBits; g++) begin : g_sq
		bsm_sqrt_cell u_cell (
			.clk, .arst_n, .adv,
			.bit_idx(6'(SqrtBits - 1 - g)),
			.vin(sv[g]), .din(sd[g]), .rin(sr[g]),
			.vout(sv[g+1]), .dout(sd[g+1]), .rout(sr[g+1])
		);
	end

	// Form radius and offset numerators.
	sq_data_t sqo;
	logic [SqrtBits-1:0] d_q;
	assign sqo = sd[SqrtBits];
	logic v_s4, v_s5;
	logic [SqrtBits:0] rw_s4;
	logic [SqrtBits-1:0] k_s4;
	sq_data_t sq_s4;
	logic [SqrtBits-1:0] d_s4;
	dv_data_t dv_s5;
	assign d_q = sr[SqrtBits];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s4 <= sv[SqrtBits];
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		logic [SqrtBits+1:0] t;
		if (adv) begin
			t = {2'b00, d_q} + (SqrtBits+2)'(sqo.r1) + (SqrtBits+2)'(sqo.r2);
			rw_s4 <= t[SqrtBits+1:1];
			// Offset scale stays at or below d, so it fits the root width.
			k_s4 <= SqrtBits'(t[SqrtBits+1:1] - (SqrtBits+1)'(sqo.r1));
			sq_s4 <= sqo;
			d_s4 <= d_q;
		end
	end

	always_ff @(posedge clk) begin
		logic [CoordW:0] mx, my, mz;
		logic pick2;
		if (adv) begin
			mx = sq_s4.dx[CoordW] ? -sq_s4.dx : sq_s4.dx;
			my = sq_s4.dy[CoordW] ? -sq_s4.dy : sq_s4.dy;
			mz = sq_s4.dz[CoordW] ? -sq_s4.dz : sq_s4.dz;
			pick2 = sq_s4.encl && !sq_s4.encl_first;
			// Enclosed case: carry the chosen center, formed as the first center plus the difference.
			dv_s5.c1x <= pick2 ? CoordW'(sq_s4.c1x + sq_s4.dx) : sq_s4.c1x;
			dv_s5.c1y <= pick2 ? CoordW'(sq_s4.c1y + sq_s4.dy) : sq_s4.c1y;
			dv_s5.c1z <= pick2 ? CoordW'(sq_s4.c1z + sq_s4.dz) : sq_s4.c1z;
			dv_s5.sx <= sq_s4.dx[CoordW];
			dv_s5.sy <= sq_s4.dy[CoordW];
			dv_s5.sz <= sq_s4.dz[CoordW];
			dv_s5.rw <= sq_s4.encl ? (sq_s4.encl_first ? (SqrtBits+1)'(sq_s4.r1)
				: (SqrtBits+1)'(sq_s4.r2)) : rw_s4;
			dv_s5.r1 <= sq_s4.r1;
			dv_s5.d <= (d_s4 == '0) ? SqrtBits'(1) : d_s4;
			dv_s5.nx <= (sq_s4.encl || d_s4 == '0) ? '0 : NumW'(mx * k_s4);
			dv_s5.ny <= (sq_s4.encl || d_s4 == '0) ? '0 : NumW'(my * k_s4);
			dv_s5.nz <= (sq_s4.encl || d_s4 == '0) ? '0 : NumW'(mz * k_s4);
			dv_s5.qx <= '0;
			dv_s5.qy <= '0;
			dv_s5.qz <= '0;
			dv_s5.remx <= '0;
			dv_s5.remy <= '0;
			dv_s5.remz <= '0;
			dv_s5.encl <= sq_s4.encl;
			dv_s5.ovl <= sq_s4.ovl;
		end
	end

	// Row of divider cells; the quotient fits in 64 bits, so the top numerator
	// bits are already below d and seed the remainder directly.
	logic dvv [DivStages+1];
	dv_data_t dvd [DivStages+1];
	dv_data_t dv_in;
	assign dvv[0] = v_s5;
	always_comb begin
		dv_in = dv_s5;
		dv_in.nx = dv_s5.nx << (NumW - QuoBits);
		dv_in.ny = dv_s5.ny << (NumW - QuoBits);
		dv_in.nz = dv_s5.nz << (NumW - QuoBits);
		dv_in.remx = (SqrtBits+1)'(dv_s5.nx[NumW-1:QuoBits]);
		dv_in.remy = (SqrtBits+1)'(dv_s5.ny[NumW-1:QuoBits]);
		dv_in.remz = (SqrtBits+1)'(dv_s5.nz[NumW-1:QuoBits]);
	end
	assign dvd[0] = dv_in;
	for (genvar g = 0; g < DivStages; g++) begin : g_dv
		bsm_div_cell u_cell (
			.clk, .arst_n, .adv,
			.vin(dvv[g]), .din(dvd[g]),
			.vout(dvv[g+1]), .dout(dvd[g+1])
		);
	end

	// Apply offsets, saturate, square.
	dv_data_t dvo;
	assign dvo = dvd[DivStages];
	logic v_s6, v_s7, v_s8, v_s9;
	logic signed [65:0] cx_s6, cy_s6, cz_s6;
	logic [SqrtBits:0] rw_s6;
	logic [RadW-1:0] r1_s6, r1_s7, rad_s7;
	logic [CoordW-1:0] ox_s7, oy_s7, oz_s7;
	logic sat_s7, ovl_s6, ovl_s7, ovl_s8;
	logic [61:0] rr_s8, r11_s8;
	logic [CoordW-1:0] ox_s8, oy_s8, oz_s8;
	logic [RadW-1:0] rad_s8;
	logic sat_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s6 <= dvv[DivStages];
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	function automatic logic [CoordW:0] clip(input logic signed [65:0] v);
		begin
			if (v > 66'sh7FFFFFFF) return {1'b1, 32'h7FFFFFFF};
			else if (v < -66'sh80000000) return {1'b1, 32'h80000000};
			else return {1'b0, v[CoordW-1:0]};
		end
	endfunction

	always_ff @(posedge clk) begin
		logic signed [65:0] qx, qy, qz;
		if (adv) begin
			qx = $signed({2'b00, dvo.qx});
			qy = $signed({2'b00, dvo.qy});
			qz = $signed({2'b00, dvo.qz});
			cx_s6 <= 66'(dvo.c1x) + (dvo.sx ? -qx : qx);
			cy_s6 <= 66'(dvo.c1y) + (dvo.sy ? -qy : qy);
			cz_s6 <= 66'(dvo.c1z) + (dvo.sz ? -qz : qz);
			rw_s6 <= dvo.rw;
			r1_s6 <= dvo.r1;
			ovl_s6 <= dvo.ovl;
		end
	end

	always_ff @(posedge clk) begin
		logic [CoordW:0] a, b, c;
		logic rad_ovf;
		if (adv) begin
			a = clip(cx_s6);
			b = clip(cy_s6);
			c = clip(cz_s6);
			rad_ovf = rw_s6 > (SqrtBits+1)'(RadMax);
			ox_s7 <= a[CoordW-1:0];
			oy_s7 <= b[CoordW-1:0];
			oz_s7 <= c[CoordW-1:0];
			rad_s7 <= rad_ovf ? RadMax : rw_s6[RadW-1:0];
			sat_s7 <= rad_ovf | a[CoordW] | b[CoordW] | c[CoordW];
			r1_s7 <= r1_s6;
			ovl_s7 <= ovl_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rr_s8 <= rad_s7 * rad_s7;
			r11_s8 <= r1_s7 * r1_s7;
			ox_s8 <= ox_s7;
			oy_s8 <= oy_s7;
			oz_s8 <= oz_s7;
			rad_s8 <= rad_s7;
			sat_s8 <= sat_s7;
			ovl_s8 <= ovl_s7;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= {1'b0, sat_s8, ovl_s8, rr_s8 - r11_s8, rad_s8, oz_s8, oy_s8, ox_s8};
		end
	end
	assign m_axis_tvalid = v_s9;

	`BSM_ASSERT(a_ready_hold, !(m_axis_tvalid && !m_axis_tready) || !s_axis_tready, "ready while stalled")
	`BSM_ASSERT(a_pad_zero, !m_axis_tvalid || m_axis_tdata[191] == 1'b0, "pad bit set")
	`BSM_ASSERT_NEXT(a_stall_keep, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "beat lost")
endmodule
